// ===== rtl/heading_pi_differential_drive_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the heading PI drive controller
// Shared concurrent-check helpers, clocked on the rising edge and idle in reset.
// ----------------------------------------------------------------------------
`ifndef HEADING_PI_DIFFERENTIAL_DRIVE_MACROS_SVH
`define HEADING_PI_DIFFERENTIAL_DRIVE_MACROS_SVH

// same-cycle implication
`define HPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hpd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpd_pkg
// Widths, codes and controller/datapath interface types of the heading PI
// drive controller.
// ----------------------------------------------------------------------------
package hpd_pkg;

    localparam int PWM_FULL_SCALE = 100;
    localparam int DUTY_W   = 7;
    localparam int HDG_W    = 9;
    localparam int SPD_W    = 11;
    localparam int DT_W     = 16;
    localparam int GAIN_W   = 16;
    localparam int FS_W     = 10;
    localparam int ERR_W    = 10;
    localparam int INTEG_W  = 18;
    localparam int EDT_W    = 27;
    localparam int CAND_W   = 28;
    localparam int PK_W     = 26;
    localparam int PI_W     = 34;
    localparam int P_W      = 36;
    localparam int FRAC_SH  = 18;
    localparam int KP_SH    = 10;
    localparam int PLO_W    = 28;
    localparam int PHI_W    = 29;
    localparam int BASE_W   = 18;
    localparam int NUM_W    = 48;
    localparam int MAG_W    = 27;
    localparam int DIV_W    = 34;
    localparam int DVS_W    = 27;
    localparam int CNT_W    = 6;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // motion modes
    localparam logic [1:0] MODE_STOP  = 2'd0;
    localparam logic [1:0] MODE_TURN  = 2'd1;
    localparam logic [1:0] MODE_DRIVE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP_TURN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_TURN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRV_KP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRV_KI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED = 3'd5;

    // datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_CAPTURE  = 4'd1;
    localparam t_op OP_ERR      = 4'd2;
    localparam t_op OP_MUL1     = 4'd3;
    localparam t_op OP_INTEG    = 4'd4;
    localparam t_op OP_MUL2     = 4'd5;
    localparam t_op OP_PSUM     = 4'd6;
    localparam t_op OP_TURN     = 4'd7;
    localparam t_op OP_PROD     = 4'd8;
    localparam t_op OP_NUM      = 4'd9;
    localparam t_op OP_DIV_GO   = 4'd10;
    localparam t_op OP_DIV_WAIT = 4'd11;
    localparam t_op OP_DRIVE    = 4'd12;
    localparam t_op OP_STOP     = 4'd13;
    localparam t_op OP_EMIT     = 4'd14;

    // divider job select
    typedef logic [1:0] t_dsel;
    localparam t_dsel DSEL_R = 2'd0;
    localparam t_dsel DSEL_L = 2'd1;
    localparam t_dsel DSEL_S = 2'd2;

    typedef struct packed {
        t_op   op;
        t_dsel dsel;
    } t_cmd;

    typedef struct packed {
        logic       is_cmd;
        logic [1:0] run_mode;
        logic       div_busy;
        logic       sat_needed;
    } t_sts;

endpackage

// ===== rtl/hpd_div.sv =====
// ----------------------------------------------------------------------------
// hpd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hpd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hpd_pkg::DIV_W-1:0]  i_dividend,
    input  logic [hpd_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [hpd_pkg::DIV_W-1:0]  o_quot
);
    import hpd_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_sh;
    logic [DVS_W:0]   w_sub;
    logic             w_ge;

    // partial remainder with next dividend bit
    assign w_sh  = {r_rem, r_q[DIV_W-1]};
    assign w_ge  = (w_sh >= {1'b0, r_dvs});
    assign w_sub = w_sh - {1'b0, r_dvs};

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DVS_W-1:0] : w_sh[DVS_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

// ===== rtl/hpd_dpath.sv =====
// ----------------------------------------------------------------------------
// hpd_dpath
// Datapath: configuration, heading error, PI integrators, drive mix with
// saturation, turn duty and the output register.
// ----------------------------------------------------------------------------
module hpd_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hpd_pkg::t_cmd                   i_cmd,
    output hpd_pkg::t_sts                   o_sts,
    input  logic [hpd_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_cfg_valid,
    input  logic [hpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [hpd_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import hpd_pkg::*;

    localparam logic [DUTY_W-1:0] FULL_DUTY = DUTY_W'(PWM_FULL_SCALE);

    // configuration
    logic signed [GAIN_W-1:0] r_kp_turn, r_ki_turn, r_drv_kp, r_drv_ki;
    logic [GAIN_W-1:0]        r_limit;
    logic [FS_W-1:0]          r_fs;

    // controller state
    logic [1:0]               r_mode;
    logic [HDG_W-1:0]         r_goal;
    logic signed [SPD_W-1:0]  r_speed;
    logic [HDG_W-1:0]         r_latest;
    logic signed [INTEG_W-1:0] r_iturn, r_idrive;
    logic [1:0]               r_dirs;
    logic                     r_is_cmd;

    // working registers
    logic [HDG_W-1:0]         r_meas;
    logic [DT_W-1:0]          r_dt;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [EDT_W-1:0]  r_edt;
    logic signed [PK_W-1:0]   r_pk;
    logic signed [PI_W-1:0]   r_pi;
    logic signed [P_W-1:0]    r_p;
    logic [PLO_W-1:0]         r_pplo;
    logic signed [PHI_W-1:0]  r_pphi;
    logic signed [BASE_W-1:0] r_base;
    logic [MAG_W-1:0]         r_rnum, r_lnum, r_rmag, r_lmag;
    logic                     r_rneg, r_lneg;
    logic [DUTY_W-1:0]        r_mq;
    logic [DUTY_W-1:0]        r_st_l, r_st_r;
    logic [1:0]               r_st_dirs;
    logic                     r_st_stop;
    logic [DUTY_W-1:0]        r_out_l, r_out_r;
    logic [1:0]               r_out_dirs;
    logic                     r_out_chg;

    // input fields
    logic                     w_func;
    logic [1:0]               w_in_mode;
    logic [HDG_W-1:0]         w_in_hdg;
    logic signed [SPD_W-1:0]  w_in_spd;
    logic [DT_W-1:0]          w_in_dt;

    logic [FS_W-1:0]          w_fs;
    logic                     w_turn;
    logic signed [ERR_W-1:0]  w_diff, w_err;
    logic signed [GAIN_W-1:0] w_kp, w_ki;
    logic signed [INTEG_W-1:0] w_integ;
    logic signed [CAND_W-1:0] w_cand;
    logic [CAND_W-1:0]        w_cand_abs;
    logic                     w_integ_ok;
    logic [P_W-1:0]           w_pabs;
    logic [FRAC_SH-1:0]       w_tq;
    logic [DUTY_W-1:0]        w_tduty;
    logic signed [NUM_W-1:0]  w_pf, w_bsh, w_nr, w_nl;
    logic [NUM_W-1:0]         w_nr_abs, w_nl_abs;
    logic                     w_r_ge_l;
    logic [MAG_W-1:0]         w_big, w_small;
    logic                     w_sat;
    logic                     w_div_start, w_div_busy;
    logic [DIV_W-1:0]         w_dividend, w_quot;
    logic [DVS_W-1:0]         w_divisor;
    logic [DUTY_W-1:0]        w_dl, w_dr;

    assign w_func    = i_s_tuser;
    assign w_in_mode = i_s_tdata[1:0];
    assign w_in_hdg  = i_s_tdata[10:2];
    assign w_in_spd  = $signed(i_s_tdata[21:11]);
    assign w_in_dt   = i_s_tdata[37:22];

    assign w_fs   = (r_fs == '0) ? FS_W'(1) : r_fs;
    assign w_turn = (r_mode == MODE_TURN);
    assign w_kp   = w_turn ? r_kp_turn : r_drv_kp;
    assign w_ki   = w_turn ? r_ki_turn : r_drv_ki;
    assign w_integ = w_turn ? r_iturn : r_idrive;

    // heading error, wrapped once
    always_comb begin
        w_diff = $signed({1'b0, r_goal}) - $signed({1'b0, r_meas});
        if (w_diff > ERR_W'(180)) begin
            w_err = w_diff - ERR_W'(360);
        end else if (w_diff < -ERR_W'(180)) begin
            w_err = w_diff + ERR_W'(360);
        end else begin
            w_err = w_diff;
        end
    end

    // conditional integrator step
    assign w_cand     = CAND_W'(w_integ) + CAND_W'(r_edt);
    assign w_cand_abs = w_cand[CAND_W-1] ? CAND_W'(-w_cand) : CAND_W'(w_cand);
    assign w_integ_ok = (w_cand_abs <= CAND_W'(r_limit));

    // turn duty
    assign w_pabs  = r_p[P_W-1] ? P_W'(-r_p) : P_W'(r_p);
    assign w_tq    = w_pabs[P_W-1:FRAC_SH];
    assign w_tduty = (w_tq > FRAC_SH'(PWM_FULL_SCALE)) ? FULL_DUTY : w_tq[DUTY_W-1:0];

    // drive numerators
    assign w_pf  = (NUM_W'(r_pphi) <<< FRAC_SH) + NUM_W'($signed({1'b0, r_pplo}));
    assign w_bsh = NUM_W'(r_base) <<< FRAC_SH;
    assign w_nr  = w_bsh + w_pf;
    assign w_nl  = w_bsh - w_pf;
    assign w_nr_abs = w_nr[NUM_W-1] ? NUM_W'(-w_nr) : NUM_W'(w_nr);
    assign w_nl_abs = w_nl[NUM_W-1] ? NUM_W'(-w_nl) : NUM_W'(w_nl);

    // saturation compare
    assign w_r_ge_l = (r_rmag >= r_lmag);
    assign w_big    = w_r_ge_l ? r_rmag : r_lmag;
    assign w_small  = w_r_ge_l ? r_lmag : r_rmag;
    assign w_sat    = (w_big > MAG_W'(PWM_FULL_SCALE));

    // final drive magnitudes
    always_comb begin
        if (!w_sat) begin
            w_dl = r_lmag[DUTY_W-1:0];
            w_dr = r_rmag[DUTY_W-1:0];
        end else if (w_r_ge_l) begin
            w_dl = r_mq;
            w_dr = FULL_DUTY;
        end else begin
            w_dl = FULL_DUTY;
            w_dr = r_mq;
        end
    end

    // divider operands
    always_comb begin
        case (i_cmd.dsel)
            DSEL_R: begin
                w_dividend = DIV_W'(r_rnum);
                w_divisor  = DVS_W'(w_fs);
            end
            DSEL_L: begin
                w_dividend = DIV_W'(r_lnum);
                w_divisor  = DVS_W'(w_fs);
            end
            default: begin
                w_dividend = DIV_W'(w_small) * DIV_W'(PWM_FULL_SCALE);
                w_divisor  = DVS_W'(w_big);
            end
        endcase
    end

    assign w_div_start = (i_cmd.op == OP_DIV_GO);

    hpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    // configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_turn  <= '0;
            r_ki_turn  <= '0;
            r_drv_kp   <= '0;
            r_drv_ki   <= '0;
            r_limit    <= GAIN_W'(5120);
            r_fs       <= FS_W'(400);
            r_mode     <= MODE_STOP;
            r_goal     <= '0;
            r_speed    <= '0;
            r_latest   <= HDG_W'(90);
            r_iturn    <= '0;
            r_idrive   <= '0;
            r_dirs     <= '0;
            r_is_cmd   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KP_TURN:    r_kp_turn  <= $signed(i_cfg_data);
                    CFG_KI_TURN:    r_ki_turn  <= $signed(i_cfg_data);
                    CFG_DRV_KP:     r_drv_kp   <= $signed(i_cfg_data);
                    CFG_DRV_KI:     r_drv_ki   <= $signed(i_cfg_data);
                    CFG_INT_LIMIT:  r_limit    <= i_cfg_data;
                    CFG_FULL_SPEED: r_fs       <= i_cfg_data[FS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_CAPTURE) begin
                r_is_cmd <= !w_func;
                if (!w_func) begin
                    r_mode  <= (w_in_mode == MODE_TURN || w_in_mode == MODE_DRIVE)
                               ? w_in_mode : MODE_STOP;
                    r_goal  <= w_in_hdg;
                    r_speed <= w_in_spd;
                end else begin
                    r_latest <= w_in_hdg;
                end
            end
            if (i_cmd.op == OP_INTEG && w_integ_ok) begin
                if (w_turn) begin
                    r_iturn <= w_cand[INTEG_W-1:0];
                end else begin
                    r_idrive <= w_cand[INTEG_W-1:0];
                end
            end
            if (i_cmd.op == OP_EMIT && !r_st_stop) begin
                r_dirs <= r_st_dirs;
            end
        end
    end

    // working registers, stepped by the controller
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_meas <= w_func ? w_in_hdg : r_latest;
                r_dt   <= w_func ? w_in_dt : '0;
            end
            OP_ERR: r_err <= w_err;
            OP_MUL1: begin
                r_edt <= EDT_W'(r_err) * EDT_W'($signed({1'b0, r_dt}));
                r_pk  <= PK_W'(r_err) * PK_W'(w_kp);
            end
            OP_MUL2: r_pi <= PI_W'(w_integ) * PI_W'(w_ki);
            OP_PSUM: r_p  <= (P_W'(r_pk) <<< KP_SH) + P_W'(r_pi);
            OP_TURN: begin
                r_st_l    <= w_tduty;
                r_st_r    <= w_tduty;
                r_st_dirs <= r_err[ERR_W-1] ? 2'b10 : 2'b01;
                r_st_stop <= 1'b0;
            end
            OP_PROD: begin
                r_pplo <= PLO_W'(r_p[FRAC_SH-1:0]) * PLO_W'(w_fs);
                r_pphi <= PHI_W'($signed(r_p[P_W-1:FRAC_SH]))
                          * PHI_W'($signed({1'b0, w_fs}));
                r_base <= BASE_W'(r_speed) * BASE_W'(PWM_FULL_SCALE);
            end
            OP_NUM: begin
                r_rnum <= w_nr_abs[FRAC_SH+MAG_W-1:FRAC_SH];
                r_lnum <= w_nl_abs[FRAC_SH+MAG_W-1:FRAC_SH];
                r_rneg <= w_nr[NUM_W-1];
                r_lneg <= w_nl[NUM_W-1];
            end
            OP_DIV_WAIT: begin
                if (!w_div_busy) begin
                    case (i_cmd.dsel)
                        DSEL_R:  r_rmag <= w_quot[MAG_W-1:0];
                        DSEL_L:  r_lmag <= w_quot[MAG_W-1:0];
                        default: r_mq   <= w_quot[DUTY_W-1:0];
                    endcase
                end
            end
            OP_DRIVE: begin
                r_st_l    <= w_dl;
                r_st_r    <= w_dr;
                r_st_dirs <= {r_rneg && (w_dr != '0), r_lneg && (w_dl != '0)};
                r_st_stop <= 1'b0;
            end
            OP_STOP: begin
                r_st_l    <= '0;
                r_st_r    <= '0;
                r_st_stop <= 1'b1;
            end
            OP_EMIT: begin
                r_out_l    <= r_st_l;
                r_out_r    <= r_st_r;
                r_out_dirs <= r_st_stop ? r_dirs : r_st_dirs;
                r_out_chg  <= !r_st_stop && (r_st_dirs != r_dirs);
            end
            default: ;
        endcase
    end

    assign o_sts.is_cmd     = r_is_cmd;
    assign o_sts.run_mode   = r_mode;
    assign o_sts.div_busy   = w_div_busy;
    assign o_sts.sat_needed = w_sat;

    // left[6:0], right[13:7], left_rev[14], right_rev[15], changed[16]
    assign o_m_tdata = {7'b0, r_out_chg, r_out_dirs[1], r_out_dirs[0], r_out_r, r_out_l};

endmodule

// ===== rtl/hpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpd_ctrl
// Sequencer: steps the datapath through one item and owns the handshakes.
// ----------------------------------------------------------------------------
`include "heading_pi_differential_drive_macros.svh"

module hpd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    output hpd_pkg::t_cmd  o_cmd,
    input  hpd_pkg::t_sts  i_sts
);
    import hpd_pkg::*;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_DECIDE    = 5'd1;
    localparam logic [4:0] ST_ERR       = 5'd2;
    localparam logic [4:0] ST_MUL1      = 5'd3;
    localparam logic [4:0] ST_INTEG     = 5'd4;
    localparam logic [4:0] ST_MUL2      = 5'd5;
    localparam logic [4:0] ST_PSUM      = 5'd6;
    localparam logic [4:0] ST_TURN      = 5'd7;
    localparam logic [4:0] ST_PROD      = 5'd8;
    localparam logic [4:0] ST_NUM       = 5'd9;
    localparam logic [4:0] ST_DIVR_GO   = 5'd10;
    localparam logic [4:0] ST_DIVR_WAIT = 5'd11;
    localparam logic [4:0] ST_DIVL_GO   = 5'd12;
    localparam logic [4:0] ST_DIVL_WAIT = 5'd13;
    localparam logic [4:0] ST_SATCHK    = 5'd14;
    localparam logic [4:0] ST_DIVS_GO   = 5'd15;
    localparam logic [4:0] ST_DIVS_WAIT = 5'd16;
    localparam logic [4:0] ST_DRIVE     = 5'd17;
    localparam logic [4:0] ST_STOP      = 5'd18;
    localparam logic [4:0] ST_EMIT      = 5'd19;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_m_tready;

    // next state and datapath command
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd.op    = OP_NONE;
        o_cmd.dsel  = DSEL_R;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_sts.run_mode == MODE_TURN || i_sts.run_mode == MODE_DRIVE) begin
                    n_state = ST_ERR;
                end else if (i_sts.is_cmd) begin
                    n_state = ST_STOP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.op = OP_MUL1;
                n_state  = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.op = OP_INTEG;
                n_state  = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.op = OP_MUL2;
                n_state  = ST_PSUM;
            end
            ST_PSUM: begin
                o_cmd.op = OP_PSUM;
                n_state  = (i_sts.run_mode == MODE_TURN) ? ST_TURN : ST_PROD;
            end
            ST_TURN: begin
                o_cmd.op = OP_TURN;
                n_state  = ST_EMIT;
            end
            ST_PROD: begin
                o_cmd.op = OP_PROD;
                n_state  = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.op = OP_NUM;
                n_state  = ST_DIVR_GO;
            end
            ST_DIVR_GO: begin
                o_cmd.op = OP_DIV_GO;
                n_state  = ST_DIVR_WAIT;
            end
            ST_DIVR_WAIT: begin
                o_cmd.op = OP_DIV_WAIT;
                if (!i_sts.div_busy) begin
                    n_state = ST_DIVL_GO;
                end
            end
            ST_DIVL_GO: begin
                o_cmd.op   = OP_DIV_GO;
                o_cmd.dsel = DSEL_L;
                n_state    = ST_DIVL_WAIT;
            end
            ST_DIVL_WAIT: begin
                o_cmd.op   = OP_DIV_WAIT;
                o_cmd.dsel = DSEL_L;
                if (!i_sts.div_busy) begin
                    n_state = ST_SATCHK;
                end
            end
            ST_SATCHK: begin
                n_state = i_sts.sat_needed ? ST_DIVS_GO : ST_DRIVE;
            end
            ST_DIVS_GO: begin
                o_cmd.op   = OP_DIV_GO;
                o_cmd.dsel = DSEL_S;
                n_state    = ST_DIVS_WAIT;
            end
            ST_DIVS_WAIT: begin
                o_cmd.op   = OP_DIV_WAIT;
                o_cmd.dsel = DSEL_S;
                if (!i_sts.div_busy) begin
                    n_state = ST_DRIVE;
                end
            end
            ST_DRIVE: begin
                o_cmd.op = OP_DRIVE;
                n_state  = ST_EMIT;
            end
            ST_STOP: begin
                o_cmd.op = OP_STOP;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    o_cmd.op    = OP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    // checks
    `HPD_ASSERT_IMP(a_idle_div_quiet, i_clk, i_rst_n, r_state == ST_IDLE, !i_sts.div_busy, "divider busy while accepting")
    `HPD_ASSERT_IMP(a_emit_slot_free, i_clk, i_rst_n, o_cmd.op == OP_EMIT, w_slot_free, "result overwrites pending transfer")
    `HPD_ASSERT_NXT(a_div_starts, i_clk, i_rst_n, o_cmd.op == OP_DIV_GO, i_sts.div_busy, "divider did not start")
    `HPD_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, o_cmd.op == OP_EMIT, o_m_tvalid, "emitted result not presented")

endmodule

// ===== rtl/heading_pi_differential_drive.sv =====
// ----------------------------------------------------------------------------
// heading_pi_differential_drive
// Heading PI controller for a differential-drive base, top level.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (i_s_*): one item per transfer. tuser is func (0 command,
//   1 heading sample). Commands set mode, goal heading and speed; samples
//   update the measured heading and step the active PI loop.
//   Output stream (o_m_*): at most one result per input item, the left and
//   right duty, reverse flags and a direction-changed event.
//   Config channel (i_cfg_*): register writes, always ready; write only
//   while the block is idle.
//   Timing: one item at a time. A stop command and a turn update each give
//   one result; a drive update runs the serial divider twice, or three
//   times when one wheel saturates. A sample in stop mode gives no result.
//   A finished result sits in the output register while the next item is
//   taken; if the receiver stalls, the following result waits for it.
//   Reset: gains 0, integral limit 5120, full speed 400, stop mode, heading
//   90, integrators cleared, both wheels forward, no result pending.
// ----------------------------------------------------------------------------
module heading_pi_differential_drive (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // mode[1:0], heading_deg[10:2], target_speed[21:11], sample_interval[37:22]
    input  logic [hpd_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // func
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // left_duty[6:0], right_duty[13:7], left_reverse[14], right_reverse[15],
    // direction_changed[16]
    output logic [hpd_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hpd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hpd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    hpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    hpd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// ===== tb/heading_pi_differential_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pi_differential_drive_checker
// Watches the input, output and register channels of the heading controller,
// predicts each duty/direction result and compares it field by field.
// ----------------------------------------------------------------------------
module heading_pi_differential_drive_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [hpd_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic                                i_s_tuser,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [hpd_pkg::M_TDATA_W-1:0]       i_m_tdata,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [hpd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hpd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import hpd_pkg::*;

    typedef struct packed {
        logic       changed;
        logic       right_rev;
        logic       left_rev;
        logic [6:0] right_duty;
        logic [6:0] left_duty;
    } t_drive_out;

    // predictor copy of registers and state
    longint kp_turn, ki_turn, drv_kp, drv_ki, int_limit, full_spd;
    logic [1:0] run_mode;
    longint goal_hdg, goal_spd, meas_hdg, drive_acc, turn_acc;
    logic [1:0] cur_dirs, rep_dirs;

    t_drive_out duty_queue[$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = duty_queue.size();

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint wrap_err(longint meas);
        longint e;
        e = goal_hdg - meas;
        if (e > 180) e -= 360;
        else if (e < -180) e += 360;
        return e;
    endfunction

    function automatic void push_result(longint ld, longint rd, logic [1:0] dirs);
        t_drive_out r;
        cur_dirs     = dirs;
        r.changed    = (cur_dirs != rep_dirs);
        rep_dirs     = cur_dirs;
        r.left_duty  = ld[6:0];
        r.right_duty = rd[6:0];
        r.left_rev   = dirs[0];
        r.right_rev  = dirs[1];
        duty_queue.push_back(r);
    endfunction

    function automatic void spin_update(longint meas, longint dt);
        longint e, cand, p, duty;
        e    = wrap_err(meas);
        cand = turn_acc + e * dt;
        if (mag(cand) <= int_limit) turn_acc = cand;
        p    = e * kp_turn * 1024 + turn_acc * ki_turn;
        duty = mag(p) / 262144;
        if (duty > PWM_FULL_SCALE) duty = PWM_FULL_SCALE;
        push_result(duty, duty, e >= 0 ? 2'b01 : 2'b10);
    endfunction

    function automatic void drive_update(longint meas, longint dt);
        longint e, cand, p, fs, base, den, r, l, ar, al, m;
        e    = wrap_err(meas);
        fs   = full_spd ? full_spd : 1;
        cand = drive_acc + e * dt;
        if (mag(cand) <= int_limit) drive_acc = cand;
        p    = e * drv_kp * 1024 + drive_acc * drv_ki;
        base = goal_spd * PWM_FULL_SCALE * 262144;
        den  = fs * 262144;
        r    = (base + p * fs) / den;
        l    = (base - p * fs) / den;
        ar   = mag(r);
        al   = mag(l);
        if (ar >= al) begin
            if (ar > PWM_FULL_SCALE) begin
                m = (PWM_FULL_SCALE * al) / ar;
                r = r < 0 ? -PWM_FULL_SCALE : PWM_FULL_SCALE;
                l = l < 0 ? -m : m;
            end
        end else if (al > PWM_FULL_SCALE) begin
            m = (PWM_FULL_SCALE * ar) / al;
            l = l < 0 ? -PWM_FULL_SCALE : PWM_FULL_SCALE;
            r = r < 0 ? -m : m;
        end
        push_result(mag(l), mag(r), {r < 0, l < 0});
    endfunction

    function automatic void take_item(logic [S_TDATA_W-1:0] d, logic is_sample);
        logic [1:0] md;
        longint hdg, dt;
        md  = d[1:0];
        hdg = longint'(d[10:2]);
        dt  = longint'(d[37:22]);
        if (!is_sample) begin
            if (md != MODE_TURN && md != MODE_DRIVE) md = MODE_STOP;
            run_mode = md;
            goal_hdg = hdg;
            goal_spd = longint'(signed'(d[21:11]));
            if (md == MODE_TURN) spin_update(meas_hdg, 0);
            else if (md == MODE_DRIVE) drive_update(meas_hdg, 0);
            else push_result(0, 0, cur_dirs) ;
            if (md == MODE_STOP) duty_queue[$].changed = 1'b0;
        end else begin
            meas_hdg = hdg;
            if (run_mode == MODE_TURN) spin_update(hdg, dt);
            else if (run_mode == MODE_DRIVE) drive_update(hdg, dt);
        end
    endfunction

    // stop result must not touch reported pair; push_result did, so restore
    // by tracking: stop re-emits cur_dirs which equals rep_dirs already.

    always @(posedge i_clk) begin
        t_drive_out want, got;
        if (!i_rst_n) begin
            kp_turn = 0; ki_turn = 0; drv_kp = 0; drv_ki = 0;
            int_limit = 5120; full_spd = 400;
            run_mode = MODE_STOP; goal_hdg = 0; goal_spd = 0; meas_hdg = 90;
            drive_acc = 0; turn_acc = 0; cur_dirs = 0; rep_dirs = 0;
            duty_queue.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KP_TURN:    kp_turn   = longint'(signed'(i_cfg_data));
                    CFG_KI_TURN:    ki_turn   = longint'(signed'(i_cfg_data));
                    CFG_DRV_KP:     drv_kp    = longint'(signed'(i_cfg_data));
                    CFG_DRV_KI:     drv_ki    = longint'(signed'(i_cfg_data));
                    CFG_INT_LIMIT:  int_limit = longint'(i_cfg_data);
                    CFG_FULL_SPEED: full_spd  = longint'(i_cfg_data[FS_W-1:0]);
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[16:0];
                if (duty_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result %h", got);
                end else begin
                    want = duty_queue.pop_front();
                    if (want != got || i_m_tdata[M_TDATA_W-1:17] != 0) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp %0d %0d %b %b %b, got %0d %0d %b %b %b",
                                want.left_duty, want.right_duty, want.left_rev,
                                want.right_rev, want.changed, got.left_duty,
                                got.right_duty, got.left_rev, got.right_rev,
                                got.changed);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) take_item(i_s_tdata, i_s_tuser);
        end
    end
endmodule

// ===== tb/heading_pi_differential_drive_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pi_differential_drive_tb
// Drives commands, heading samples and gain settings into the controller
// with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module heading_pi_differential_drive_tb;
    import hpd_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [S_TDATA_W-1:0]   s_data = '0;
    logic                   s_user = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [M_TDATA_W-1:0]   m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     fail_count, pending;
    int                     idle_cycles = 0;
    bit                     stall_on = 1'b1;

    always #1 i_clk = ~i_clk;

    heading_pi_differential_drive i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready),
        .i_s_tdata(s_data), .i_s_tuser(s_user),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    heading_pi_differential_drive_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready),
        .i_s_tdata(s_data), .i_s_tuser(s_user),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
        return $urandom_range(0, 3);
    endfunction

    // receiver stalls, mostly short
    always @(posedge i_clk) begin
        if (!stall_on) m_ready <= 1'b1;
        else if ($urandom_range(0, 3) == 0) m_ready <= ~m_ready;
        else if (!m_ready && $urandom_range(0, 1) == 0) m_ready <= 1'b1;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("heading_pi_differential_drive_tb failed");
            $finish;
        end
    end

    task automatic send_item(logic is_sample, logic [1:0] md, logic [8:0] hdg,
                             logic [10:0] spd, logic [15:0] dt);
        int g;
        g = gap_len();
        repeat (g) @(posedge i_clk);
        s_valid <= 1'b1;
        s_user  <= is_sample;
        s_data  <= {2'b0, dt, spd, hdg, md};
        do @(posedge i_clk); while (!s_ready);
        s_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait for all results, then let a trailing stop-mode sample finish
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_gains(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] d, logic [15:0] lim, logic [15:0] fs);
        write_reg(CFG_KP_TURN, a);
        write_reg(CFG_KI_TURN, b);
        write_reg(CFG_DRV_KP, c);
        write_reg(CFG_DRV_KI, d);
        write_reg(CFG_INT_LIMIT, lim);
        write_reg(CFG_FULL_SPEED, fs);
    endtask

    task automatic random_item();
        logic [1:0] md;
        int r;
        r = $urandom_range(0, 9);
        md = r < 4 ? MODE_DRIVE : (r < 7 ? MODE_TURN : r < 9 ? MODE_STOP : 2'd3);
        if ($urandom_range(0, 3) == 0)
            send_item(1'b0, md, 9'($urandom_range(0, 511)), 11'($urandom),
                      16'($urandom));
        else
            send_item(1'b1, 2'($urandom),
                      ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                  : 9'($urandom_range(0, 359)),
                      11'($urandom),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 200)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset gains, then extremes
        send_item(1'b1, MODE_STOP, 9'd10, 11'd0, 16'd5);
        send_item(1'b0, MODE_STOP, 9'd0, 11'd0, 16'd0);
        send_item(1'b0, MODE_DRIVE, 9'd0, 11'd1023, 16'd0);
        send_item(1'b0, MODE_DRIVE, 9'd359, 11'h401, 16'd0);
        drain();
        set_gains(16'h0200, 16'h0010, 16'h0180, 16'h0008, 16'd5120, 16'd400);
        send_item(1'b0, MODE_TURN, 9'd180, 11'd0, 16'd0);
        send_item(1'b1, MODE_STOP, 9'd0, 11'd0, 16'd100);
        send_item(1'b1, MODE_STOP, 9'd359, 11'd0, 16'hFFFF);
        send_item(1'b1, MODE_STOP, 9'd511, 11'd0, 16'd3);
        send_item(1'b0, MODE_DRIVE, 9'd270, 11'd300, 16'd0);
        send_item(1'b1, MODE_STOP, 9'd90, 11'd0, 16'd50);
        send_item(1'b1, MODE_STOP, 9'd300, 11'd0, 16'd20);
        send_item(1'b0, MODE_DRIVE, 9'd0, 11'h7FF, 16'd0);
        send_item(1'b1, MODE_STOP, 9'd0, 11'd0, 16'd0);
        send_item(1'b0, 2'd3, 9'd5, 11'd5, 16'd0);
        send_item(1'b1, MODE_STOP, 9'd45, 11'd0, 16'd0);
        drain();
        set_gains(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'd0);
        send_item(1'b0, MODE_DRIVE, 9'd10, 11'd1023, 16'd0);
        send_item(1'b1, MODE_STOP, 9'd200, 11'd0, 16'hFFFF);
        send_item(1'b0, MODE_TURN, 9'd511, 11'd0, 16'd0);
        send_item(1'b1, MODE_STOP, 9'd1, 11'd0, 16'hFFFF);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            stall_on = (ph != 2);
            case (ph)
                0: set_gains(16'h0100, 16'h0004, 16'h0100, 16'h0004, 16'd5120, 16'd400);
                1: set_gains(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
                2: set_gains(16'hFF00, 16'h0040, 16'h0080, 16'hFFC0, 16'd0, 16'd1023);
                3: set_gains(16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'd200, 16'd1);
                default: set_gains(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 64)),
                                   16'($urandom_range(0, 2048)), 16'($urandom_range(0, 64)),
                                   16'($urandom), 16'($urandom_range(1, 1023)));
            endcase
            for (int n = 0; n < 200; n++) random_item();
            drain();
        end

        if (fail_count == 0)
            $display("heading_pi_differential_drive_tb passed");
        else
            $display("heading_pi_differential_drive_tb failed");
        $finish;
    end
endmodule
